// File: src/keypad_scan_setpoint_entry_defines.svh
// Assertion helpers used by the keypad scan/setpoint-entry top module.
`ifndef KEYPAD_SCAN_SETPOINT_ENTRY_DEFINES_SVH
`define KEYPAD_SCAN_SETPOINT_ENTRY_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define KPSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kpse assertion failed");

// Next-cycle implication, disabled in reset.
`define KPSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kpse assertion failed");

`endif

// File: src/kpse_pkg.sv
`timescale 1ns / 1ps
package kpse_pkg;

  localparam int KEY_COUNT       = 12;
  localparam int SETPOINT_DIGITS = 4;
  localparam int ROWS            = 3;

  localparam int ROW_W   = 3;
  localparam int COL_W   = 4;
  localparam int KEY_W   = 4;
  localparam int CNT_W   = 5;
  localparam int STEP_W  = 3;
  localparam int SP_W    = 14;
  localparam int DIGIT_W = 4;
  localparam int RIDX_W  = $clog2(ROWS);
  localparam int CIDX_W  = $clog2(COL_W);
  localparam int DIDX_W  = $clog2(SETPOINT_DIGITS);
  localparam int CFG_IDX_W = 1;

  localparam logic [KEY_W-1:0] STAR_KEY = KEY_W'(9);
  localparam logic [KEY_W-1:0] ZERO_KEY = KEY_W'(10);
  localparam logic [KEY_W-1:0] HASH_KEY = KEY_W'(11);

  localparam logic [CNT_W-1:0] PRESS_RESET   = CNT_W'(24);
  localparam logic [CNT_W-1:0] RELEASE_RESET = CNT_W'(24);

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0] STEP_WAIT_STAR  = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_FIRST_DIG  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_LAST_DIG   = STEP_W'(SETPOINT_DIGITS);
  localparam logic [STEP_W-1:0] STEP_WAIT_HASH  = STEP_W'(SETPOINT_DIGITS + 1);

  typedef struct packed {
    logic             accepted;
    logic [KEY_W-1:0] key;
  } key_evt_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              loaded;
    logic [SP_W-1:0]   setpoint;
  } entry_res_t;

  function automatic logic [RIDX_W-1:0] row_of(input logic [KEY_W-1:0] pos);
    logic [RIDX_W-1:0] r;
    case (pos)
      4'd0, 4'd3, 4'd6, 4'd9:  r = RIDX_W'(0);
      4'd1, 4'd4, 4'd7, 4'd10: r = RIDX_W'(1);
      4'd2, 4'd5, 4'd8, 4'd11: r = RIDX_W'(2);
      default:                 r = RIDX_W'(0);
    endcase
    return r;
  endfunction

  function automatic logic [CIDX_W-1:0] col_of(input logic [KEY_W-1:0] pos);
    logic [CIDX_W-1:0] c;
    case (pos)
      4'd0, 4'd1, 4'd2:   c = CIDX_W'(0);
      4'd3, 4'd4, 4'd5:   c = CIDX_W'(1);
      4'd6, 4'd7, 4'd8:   c = CIDX_W'(2);
      4'd9, 4'd10, 4'd11: c = CIDX_W'(3);
      default:            c = CIDX_W'(0);
    endcase
    return c;
  endfunction

  function automatic logic [COL_W-1:0] drive_for(input logic [KEY_W-1:0] pos);
    logic [COL_W-1:0] d;
    d = '1;
    d[col_of(pos)] = 1'b0;
    return d;
  endfunction

  function automatic logic is_digit_key(input logic [KEY_W-1:0] key);
    return (key < STAR_KEY) || (key == ZERO_KEY);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [KEY_W-1:0] key);
    return (key == ZERO_KEY) ? DIGIT_W'(0) : DIGIT_W'(key + KEY_W'(1));
  endfunction

endpackage

// File: src/kpse_stream_if.sv
`timescale 1ns / 1ps
interface kpse_in_if import kpse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_levels;

  modport source (output valid, output row_levels, input ready);
  modport sink (input valid, input row_levels, output ready);
endinterface

interface kpse_out_if import kpse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  column_drive;
  logic              key_accepted;
  logic [KEY_W-1:0]  key_index;
  logic [STEP_W-1:0] entry_position;
  logic              setpoint_loaded;
  logic [SP_W-1:0]   setpoint_value;

  modport source (output valid, output column_drive, output key_accepted,
                  output key_index, output entry_position, output setpoint_loaded,
                  output setpoint_value, input ready);
  modport sink (input valid, input column_drive, input key_accepted,
                input key_index, input entry_position, input setpoint_loaded,
                input setpoint_value, output ready);
endinterface

// File: src/kpse_scan.sv
`timescale 1ns / 1ps
module kpse_scan import kpse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [ROW_W-1:0] rows_i,
  input  logic [CNT_W-1:0] press_ticks_i,
  input  logic [CNT_W-1:0] release_ticks_i,
  output key_evt_t         evt_o,
  output logic [COL_W-1:0] column_drive_o
);

  logic [KEY_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] press_cnt_q, press_cnt_d;
  logic [KEY_W-1:0] cand_q, cand_d;
  logic             await_q, await_d;
  logic [CNT_W-1:0] rel_cnt_q, rel_cnt_d;
  logic             pressed;
  logic [CNT_W-1:0] reload;

  assign reload = (release_ticks_i == '0) ? CNT_W'(1) : release_ticks_i;

  always_comb begin
    pos_d       = pos_q;
    press_cnt_d = press_cnt_q;
    cand_d      = cand_q;
    await_d     = await_q;
    rel_cnt_d   = rel_cnt_q;
    evt_o       = '0;
    pressed     = !rows_i[row_of(pos_q)];
    if (pos_q >= KEY_W'(KEY_COUNT)) begin
      pos_d = '0;
    end else begin
      if (await_q) begin
        if (pressed) begin
          rel_cnt_d = reload;
        end else if (rel_cnt_q <= CNT_W'(1)) begin
          await_d   = 1'b0;
          rel_cnt_d = reload;
        end else begin
          rel_cnt_d = rel_cnt_q - CNT_W'(1);
        end
      end else if (press_cnt_q == '0) begin
        if (pressed && (press_ticks_i != '0)) begin
          cand_d      = pos_q;
          press_cnt_d = press_ticks_i;
        end
      end else begin
        press_cnt_d = press_cnt_q - CNT_W'(1);
        if ((press_cnt_d == '0) && pressed && (pos_q == cand_q)) begin
          evt_o.accepted = 1'b1;
          evt_o.key      = cand_q;
          await_d        = 1'b1;
          rel_cnt_d      = reload;
        end
      end
      pos_d = (pos_q == KEY_W'(KEY_COUNT - 1)) ? '0 : pos_q + KEY_W'(1);
    end
    column_drive_o = drive_for(pos_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      press_cnt_q <= '0;
      cand_q      <= '0;
      await_q     <= 1'b0;
      rel_cnt_q   <= RELEASE_RESET;
    end else if (en_i) begin
      pos_q       <= pos_d;
      press_cnt_q <= press_cnt_d;
      cand_q      <= cand_d;
      await_q     <= await_d;
      rel_cnt_q   <= rel_cnt_d;
    end
  end

endmodule

// File: src/kpse_entry.sv
`timescale 1ns / 1ps
module kpse_entry import kpse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  key_evt_t   evt_i,
  output entry_res_t res_o
);

  logic [STEP_W-1:0]  step_q, step_d;
  logic [DIGIT_W-1:0] dig_q [SETPOINT_DIGITS];
  logic [DIGIT_W-1:0] dig_d [SETPOINT_DIGITS];
  logic [SP_W-1:0]    sp_q, sp_d;
  logic [SP_W-1:0]    value;
  logic [DIDX_W-1:0]  widx;
  logic               loaded;

  always_comb begin
    value = '0;
    for (int i = 0; i < SETPOINT_DIGITS; i++) begin
      value = SP_W'(value * SP_W'(10)) + SP_W'(dig_q[i]);
    end
  end

  assign widx = DIDX_W'(step_q - STEP_FIRST_DIG);

  always_comb begin
    step_d = step_q;
    dig_d  = dig_q;
    sp_d   = sp_q;
    loaded = 1'b0;
    if (evt_i.accepted) begin
      if ((step_q >= STEP_FIRST_DIG) && (step_q <= STEP_LAST_DIG)) begin
        if (is_digit_key(evt_i.key)) begin
          dig_d[widx] = digit_of(evt_i.key);
          step_d      = step_q + STEP_W'(1);
        end
      end else if (step_q == STEP_WAIT_HASH) begin
        if (evt_i.key == HASH_KEY) begin
          sp_d   = value;
          loaded = 1'b1;
          step_d = STEP_WAIT_STAR;
        end
      end else begin
        step_d = (evt_i.key == STAR_KEY) ? STEP_FIRST_DIG : STEP_WAIT_STAR;
      end
    end
    res_o.step     = step_d;
    res_o.loaded   = loaded;
    res_o.setpoint = sp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT_STAR;
      sp_q   <= '0;
      for (int i = 0; i < SETPOINT_DIGITS; i++) begin
        dig_q[i] <= '0;
      end
    end else if (en_i) begin
      step_q <= step_d;
      sp_q   <= sp_d;
      dig_q  <= dig_d;
    end
  end

endmodule

// File: src/keypad_scan_setpoint_entry.sv
`timescale 1ns / 1ps
// channel | dir | payload                                         | beat when
// in_i    | in  | row_levels                                      | valid && ready
// out_o   | out | column_drive, key_accepted, key_index,          | valid && ready
//         |     | entry_position, setpoint_loaded, setpoint_value |
// cfg     | in  | cfg_idx_i, cfg_data_i                           | cfg_we_i
//
// One result per input beat, one beat per cycle while the output is not stalled.
// Data pass the input register and then the result register; the per-tick
// scan/debounce and entry update sit between them.
// Async active-low reset restores press/release ticks to 24 and resets the valid flags and scan/entry state.
// An output stall holds the result register and then the input register;
// input ready drops only when both are full.
`include "keypad_scan_setpoint_entry_defines.svh"
module keypad_scan_setpoint_entry import kpse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  kpse_in_if.sink              in_i,
  kpse_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  logic [CNT_W-1:0] press_q, release_q;
  logic             s1_valid_q;
  logic [ROW_W-1:0] s1_rows_q;
  logic             out_valid_q;
  logic             advance, step_en;
  key_evt_t         evt;
  entry_res_t       res;
  logic [COL_W-1:0] drive;

  logic [COL_W-1:0]  col_q;
  logic              acc_q;
  logic [KEY_W-1:0]  key_q;
  logic [STEP_W-1:0] pos_q;
  logic              ld_q;
  logic [SP_W-1:0]   sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q   <= PRESS_RESET;
      release_q <= RELEASE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESS_TICKS:   press_q   <= cfg_data_i;
        CFG_RELEASE_TICKS: release_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign step_en    = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_rows_q <= in_i.row_levels;
    end
  end

  kpse_scan u_scan (
    .clk_i,
    .rst_ni,
    .en_i           (step_en),
    .rows_i         (s1_rows_q),
    .press_ticks_i  (press_q),
    .release_ticks_i(release_q),
    .evt_o          (evt),
    .column_drive_o (drive)
  );

  kpse_entry u_entry (
    .clk_i,
    .rst_ni,
    .en_i (step_en),
    .evt_i(evt),
    .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      col_q <= drive;
      acc_q <= evt.accepted;
      key_q <= evt.key;
      pos_q <= res.step;
      ld_q  <= res.loaded;
      sp_q  <= res.setpoint;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.column_drive    = col_q;
  assign out_o.key_accepted    = acc_q;
  assign out_o.key_index       = key_q;
  assign out_o.entry_position  = pos_q;
  assign out_o.setpoint_loaded = ld_q;
  assign out_o.setpoint_value  = sp_q;

  `KPSE_ASSERT_IMP(a_one_column, clk_i, rst_ni, out_valid_q, $onehot(~col_q))
  `KPSE_ASSERT_IMP(a_idle_key, clk_i, rst_ni, out_valid_q && !acc_q, key_q == '0)
  `KPSE_ASSERT_IMP(a_load_on_hash, clk_i, rst_ni, out_valid_q && ld_q,
                   acc_q && (key_q == HASH_KEY) && (pos_q == STEP_WAIT_STAR))
  `KPSE_ASSERT_IMP(a_sp_range, clk_i, rst_ni, out_valid_q, sp_q <= SP_W'(9999))
  `KPSE_ASSERT_NXT(a_skid_hold, clk_i, rst_ni, s1_valid_q && !advance, s1_valid_q)

endmodule
